[design/swm_pkg.sv]
// Package: shared types and constants of the sliding window median filter
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CFG_W    = 8;
   localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 8'd100;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type sample;
   } req_word_type;

   typedef struct packed {
      sample_type median;
   } rsp_word_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_size;
   } csr_word_type;

   typedef struct packed {
      logic fill;
      logic update;
   } sort_cmd_type;

endpackage

[design/swm_stream_if.sv]
// Interface: valid/ready channel carrying one word of a given type
interface swm_stream_if #(
   parameter type word_type = logic
) ();

   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

[design/swm_sort.sv]
// Sorted copy of the window: fill sweep, scan pass and merge pass over one memory
module swm_sort #(
   parameter int WINDOW_MAX = 128,
   localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::sort_cmd_type cmd,
   input  swm_pkg::sample_type   sample,
   input  swm_pkg::sample_type   old_value,
   input  logic [LEN_W-1:0]      len,
   output logic                  done,
   output swm_pkg::sample_type   median
);
   import swm_pkg::*;

   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 2);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_FILL  = 2'd1;
   localparam logic [1:0] PH_SCAN  = 2'd2;
   localparam logic [1:0] PH_MERGE = 2'd3;

   sample_type sort_mem [WINDOW_MAX];

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] less_ff, less_in;
   logic [IDX_W-1:0] rmv_ff, rmv_in;
   logic             found_ff, found_in;
   logic             done_ff, done_in;
   sample_type       sample_ff, old_ff, rd_ff, cur_ff, prev_ff, median_ff;

   logic [CNT_W-1:0] len_c, k_c, prv_c, ins_c, rmv_c, mid_c;
   logic [LEN_W-1:0] ins_w;
   logic             x_lt_s, x_eq_o, o_lt_s;
   logic             rd_en, mem_we, tap_en, merge_wr;
   logic [IDX_W-1:0] wr_addr;
   sample_type       wr_data;

   assign len_c  = CNT_W'(len);
   assign k_c    = cnt_ff - CNT_W'(2);
   assign prv_c  = cnt_ff - CNT_W'(1);
   assign mid_c  = CNT_W'(len >> 1);
   assign rmv_c  = CNT_W'(rmv_ff);

   // shared compare unit
   assign x_lt_s = rd_ff < sample_ff;
   assign x_eq_o = rd_ff == old_ff;
   assign o_lt_s = old_ff < sample_ff;

   // insertion rank of the new word once the old word is taken out
   assign ins_w  = less_ff - LEN_W'(o_lt_s);
   assign ins_c  = CNT_W'(ins_w);

   assign rd_en    = ((phase_ff == PH_SCAN) || (phase_ff == PH_MERGE)) && (cnt_ff < len_c);
   assign merge_wr = (phase_ff == PH_MERGE) && (cnt_ff >= CNT_W'(2));
   assign tap_en   = (phase_ff == PH_MERGE) && (cnt_ff >= CNT_W'(1));
   assign mem_we   = (phase_ff == PH_FILL) || merge_wr;

   always_comb begin
      if (phase_ff == PH_FILL) begin
         wr_addr = cnt_ff[IDX_W-1:0];
         wr_data = sample_ff;
      end else begin
         wr_addr = k_c[IDX_W-1:0];
         if (k_c < ins_c) begin
            wr_data = (k_c < rmv_c) ? cur_ff : rd_ff;
         end else if (k_c == ins_c) begin
            wr_data = sample_ff;
         end else begin
            wr_data = (k_c <= rmv_c) ? prev_ff : cur_ff;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      less_in  = less_ff;
      rmv_in   = rmv_ff;
      found_in = found_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            cnt_in = '0;
            if (cmd.fill) begin
               phase_in = PH_FILL;
            end else if (cmd.update) begin
               phase_in = PH_SCAN;
               less_in  = '0;
               found_in = 1'b0;
            end
         end
         PH_FILL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == len_c - CNT_W'(1)) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_SCAN: begin
            if (cnt_ff >= CNT_W'(1)) begin
               less_in = less_ff + LEN_W'(x_lt_s);
               if (x_eq_o && !found_ff) begin
                  rmv_in   = prv_c[IDX_W-1:0];
                  found_in = 1'b1;
               end
            end
            if (cnt_ff == len_c) begin
               phase_in = PH_MERGE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         PH_MERGE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == len_c + CNT_W'(1)) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         less_ff  <= '0;
         rmv_ff   <= '0;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         less_ff  <= less_in;
         rmv_ff   <= rmv_in;
         found_ff <= found_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill || cmd.update) begin
         sample_ff <= sample;
         old_ff    <= old_value;
      end
      if (tap_en) begin
         cur_ff  <= rd_ff;
         prev_ff <= cur_ff;
      end
      if (phase_ff == PH_FILL) begin
         median_ff <= sample_ff;
      end else if (merge_wr && (k_c == mid_c)) begin
         median_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sort_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= sort_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   assign done   = done_ff;
   assign median = median_ff;

endmodule

[design/sliding_window_median.sv]
// Top level: sliding window median filter with ring buffer and sequencer
//
// Usage:
//   req_chan carries one signed Q16.16 sample per word; rsp_chan returns one
//   word per sample, the value at rank floor(N/2) of the last N samples.
//   csr_chan writes window_size (N); 0 acts as 1, values above WINDOW_MAX
//   act as WINDOW_MAX. A write restarts the window. csr_chan and req_chan
//   are ready only while the sequencer is idle.
//   The first sample after reset or a csr write fills the whole window with
//   itself. Every later sample replaces the oldest one, with one scan and
//   one merge pass over the sorted copy, each bounded by the single read
//   port of that memory. One sample is in flight at a time; the next is
//   taken while the previous result waits in the output register. If
//   rsp_chan stalls with a result already held, the block holds the new
//   result until the output register frees up.
//   Reset sets N to 100, empties the window and drops any held result.
//   No clearing pass is needed after reset.
module sliding_window_median #(
   parameter int WINDOW_MAX = 128
) (
   input logic          clock,
   input logic          reset,
   swm_stream_if.sink   req_chan,
   swm_stream_if.source rsp_chan,
   swm_stream_if.sink   csr_chan
);
   import swm_pkg::*;

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_RESET_I = (int'(WINDOW_SIZE_RESET) == 0) ? 1 :
                                ((int'(WINDOW_SIZE_RESET) > WINDOW_MAX) ? WINDOW_MAX :
                                 int'(WINDOW_SIZE_RESET));
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(LEN_RESET_I);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RING = 2'd1;
   localparam logic [1:0] ST_SORT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   sample_type ring_mem [WINDOW_MAX];

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             primed_ff, primed_in;
   logic             lap_ff, lap_in;
   logic             use_ring_ff, use_ring_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       prime_ff, sample_ff, ring_rd_ff, rsp_median_ff;

   logic             req_accept, csr_accept, ring_we, load_rsp, ptr_wrap;
   logic [LEN_W-1:0] ptr_ext, ptr_inc;
   sort_cmd_type     sort_cmd;
   sample_type       sort_sample, old_value, sort_median;
   logic             sort_done;
   rsp_word_type     rsp_word;

   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_chan.valid;
   assign csr_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_accept     = csr_chan.valid && csr_chan.ready;

   assign ptr_ext  = LEN_W'(ptr_ff);
   assign ptr_inc  = ptr_ext + LEN_W'(1);
   assign ptr_wrap = ptr_inc >= len_ff;

   // entries not yet overwritten since priming still hold the priming word
   assign old_value   = use_ring_ff ? ring_rd_ff : prime_ff;
   assign sort_sample = sort_cmd.fill ? req_chan.data.sample : sample_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      primed_in    = primed_ff;
      lap_in       = lap_ff;
      use_ring_in  = use_ring_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sort_cmd     = '0;
      ring_we      = 1'b0;
      load_rsp     = 1'b0;
      if (csr_accept) begin
         if (csr_chan.data.window_size == '0) begin
            len_in = LEN_W'(1);
         end else if (int'(csr_chan.data.window_size) > WINDOW_MAX) begin
            len_in = LEN_W'(WINDOW_MAX);
         end else begin
            len_in = LEN_W'(csr_chan.data.window_size);
         end
         primed_in = 1'b0;
         ptr_in    = '0;
         lap_in    = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!primed_ff) begin
                  sort_cmd.fill = 1'b1;
                  primed_in     = 1'b1;
                  ptr_in        = '0;
                  lap_in        = 1'b0;
                  state_in      = ST_SORT;
               end else begin
                  ring_we     = 1'b1;
                  use_ring_in = lap_ff;
                  ptr_in      = ptr_wrap ? '0 : ptr_inc[IDX_W-1:0];
                  if (ptr_wrap) begin
                     lap_in = 1'b1;
                  end
                  state_in = ST_RING;
               end
            end
         end
         ST_RING: begin
            sort_cmd.update = 1'b1;
            state_in        = ST_SORT;
         end
         ST_SORT: begin
            if (sort_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         ptr_ff       <= '0;
         primed_ff    <= 1'b0;
         lap_ff       <= 1'b0;
         use_ring_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         primed_ff    <= primed_in;
         lap_ff       <= lap_in;
         use_ring_ff  <= use_ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_chan.data.sample;
         if (!primed_ff) begin
            prime_ff <= req_chan.data.sample;
         end
      end
      if (load_rsp) begin
         rsp_median_ff <= sort_median;
      end
   end

   // ring buffer: old word read out at the same edge the new word lands
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ptr_ff] <= req_chan.data.sample;
      end
      ring_rd_ff <= ring_mem[ptr_ff];
   end

   swm_sort #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_sort (
      .clock     (clock),
      .reset     (reset),
      .cmd       (sort_cmd),
      .sample    (sort_sample),
      .old_value (old_value),
      .len       (len_ff),
      .done      (sort_done),
      .median    (sort_median)
   );

   assign rsp_word.median = rsp_median_ff;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_word;

   a_fill_primes: assert property (@(posedge clock) disable iff (reset)
      req_accept && !primed_ff |=> primed_ff && (state_ff == ST_SORT))
      else $error("priming word did not start a fill");

   a_ptr_in_window: assert property (@(posedge clock) disable iff (reset)
      ptr_ext < len_ff)
      else $error("oldest pointer outside the window");

   a_done_in_sort: assert property (@(posedge clock) disable iff (reset)
      sort_done |-> (state_ff == ST_SORT))
      else $error("sort unit finished outside the sort state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> ($past(state_ff) == ST_DONE))
      else $error("result word raised without a finished sample");

endmodule

[test/sliding_window_median_tb.sv]
// Testbench: sliding window median filter checked against a sorted-window predictor
module sliding_window_median_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import swm_pkg::*;

   localparam int WIN_MAX     = 128;
   localparam int ITEMS       = 1950;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int TAIL_CYCLES = 2 * WIN_MAX + 16;
   localparam sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   swm_stream_if #(.word_type(req_word_type)) req_if ();
   swm_stream_if #(.word_type(rsp_word_type)) rsp_if ();
   swm_stream_if #(.word_type(csr_word_type)) csr_if ();

   logic             req_valid = 1'b0;
   sample_type       req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             csr_valid = 1'b0;
   logic [CFG_W-1:0] csr_data  = '0;

   assign req_if.valid = req_valid;
   assign req_if.data  = req_word_type'(req_data);
   assign rsp_if.ready = rsp_ready;
   assign csr_if.valid = csr_valid;
   assign csr_if.data  = csr_word_type'(csr_data);

   sliding_window_median #(.WINDOW_MAX(WIN_MAX)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predictor state
   sample_type       win_mem [WIN_MAX];
   int unsigned      win_oldest   = 0;
   bit               win_primed   = 1'b0;
   logic [CFG_W-1:0] win_size_reg = WINDOW_SIZE_RESET;

   sample_type pending_samples[$];
   sample_type expected_medians[$];

   int  samples_sent  = 0;
   int  medians_seen  = 0;
   int  err_count     = 0;
   int  size_settings = 1;
   int  cycle_count   = 0;
   bit  req_taken     = 1'b0;
   bit  hold_off      = 1'b0;

   function automatic sample_type predict_median(sample_type s);
      int unsigned n;
      int unsigned p;
      int          k;
      sample_type  sorted_q[$];
      n = (win_size_reg == 0) ? 1 : ((win_size_reg > WIN_MAX) ? WIN_MAX : win_size_reg);
      if (!win_primed) begin
         for (int i = 0; i < n; i++) win_mem[i] = s;
         win_oldest = 0;
         win_primed = 1'b1;
      end else begin
         p = (win_oldest >= n) ? 0 : win_oldest;
         win_mem[p] = s;
         p++;
         win_oldest = (p >= n) ? 0 : p;
      end
      for (int i = 0; i < n; i++) begin
         k = 0;
         while (k < sorted_q.size() && sorted_q[k] <= win_mem[i]) k++;
         sorted_q.insert(k, win_mem[i]);
      end
      return sorted_q[n / 2];
   endfunction

   function automatic sample_type pick_sample(sample_type prev);
      sample_type res;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: res = sample_type'($urandom);
         4, 5, 6:    res = sample_type'($urandom_range(0, 8)) - 4;
         7:          res = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         8:          res = prev;
         default:    res = sample_type'($urandom_range(0, 65535)) <<< 16;
      endcase
      return res;
   endfunction

   function automatic void queue_sample(sample_type s);
      pending_samples.insert(pending_samples.size(), s);
   endfunction

   task automatic report(string msg);
      err_count++;
      if (err_count <= 100) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || expected_medians.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_if.ready);
      win_size_reg = v;
      win_primed   = 1'b0;
      win_oldest   = 0;
      size_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(int count);
      sample_type prev;
      prev = '0;
      repeat (count) begin
         prev = pick_sample(prev);
         queue_sample(prev);
      end
   endtask

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (!reset && req_valid && req_if.ready) begin
         pending_samples.delete(0);
         expected_medians.insert(expected_medians.size(), predict_median(req_data));
         samples_sent++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left != 0 && !hold_off) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_samples[0];
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 30);
               gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern in modes of random length
   int rx_mode    = 0;
   int rx_left    = 0;
   int rx_tick    = 0;

   always @(negedge clock) begin
      logic nxt;
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(5, 200);
      end else begin
         rx_left--;
      end
      rx_tick++;
      case (rx_mode)
         0:       nxt = 1'b1;
         1:       nxt = $urandom_range(0, 1);
         2:       nxt = ($urandom_range(0, 4) == 0);
         default: nxt = (rx_tick % 7) < 3;
      endcase
      rsp_ready <= hold_off ? 1'b0 : nxt;
   end

   // long receiver hold-off so that the block backs up into its input
   initial begin
      while (samples_sent < 500 || pending_samples.size() < 8) @(posedge clock);
      hold_off = 1'b1;
      repeat (600) @(posedge clock);
      hold_off = 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_if.valid && rsp_ready) begin
         medians_seen++;
         if (expected_medians.size() == 0) begin
            report($sformatf("median word %0d with no sample pending", rsp_if.data.median));
         end else begin
            want = expected_medians[0];
            expected_medians.delete(0);
            if (rsp_if.data.median !== want)
               report($sformatf("median got %0d expected %0d (N=%0d)",
                                rsp_if.data.median, want, win_size_reg));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d medians outstanding",
                  cycle_count, expected_medians.size());
         $display("sliding_window_median_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int sz;
      int cnt;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window size, fill then replace
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(32'sd0);
      queue_sample(-32'sd1);
      queue_sample(32'sd1);
      queue_sample(SAMPLE_MIN);
      drain();

      // size zero acts as one
      write_window(8'd0);
      queue_sample(-32'sd5);
      queue_sample(32'sd7);
      queue_sample(SAMPLE_MIN);
      drain();

      // even size: upper median, duplicates
      write_window(8'd2);
      queue_sample(32'sd10);
      queue_sample(-32'sd20);
      queue_sample(-32'sd20);
      queue_sample(32'sd30);
      queue_sample(32'sd30);
      drain();

      write_window(8'd3);
      queue_sample(32'sd4);
      queue_sample(-32'sd4);
      queue_sample(SAMPLE_MAX);
      queue_sample(32'sd4);
      drain();

      // above maximum saturates
      write_window(8'd255);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(32'sd0);
      drain();

      // full window with pointer wrap
      write_window(8'd128);
      queue_random(140);
      drain();

      write_window(8'd1);
      queue_random(30);
      drain();

      while (samples_sent < ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               sz  = $urandom_range(17, 255);
               cnt = $urandom_range(8, 30);
            end
            1: begin
               case ($urandom_range(0, 4))
                  0:       sz = 0;
                  1:       sz = 1;
                  2:       sz = 128;
                  3:       sz = 129;
                  default: sz = 255;
               endcase
               cnt = (sz <= 1) ? $urandom_range(20, 60) : $urandom_range(8, 20);
            end
            default: begin
               sz  = $urandom_range(1, 16);
               cnt = $urandom_range(20, 90);
            end
         endcase
         write_window(sz[CFG_W-1:0]);
         queue_random(cnt);
         drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_medians.size() != 0)
         report($sformatf("%0d medians never arrived", expected_medians.size()));

      $display("%0d samples, %0d medians checked across %0d window size settings",
               samples_sent, medians_seen, size_settings);
      $display("sizes included 0, 1, 2, 3, 100 (reset), 128, 255 and random ones; %0d mismatches",
               err_count);
      if (err_count == 0) begin
         $display("sliding_window_median_tb OK");
      end else begin
         $display("sliding_window_median_tb NOT OK");
      end
      $finish;
   end

endmodule
